>>> sv/two_level_page_table_mapper_unit_macros.svh
// Assertion macros shared by the mapper RTL.
`ifndef TWO_LEVEL_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
// Implication checked every clock edge outside reset.
`define TLPM_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define TLPM_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> sv/tlpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared types and constants of the two-level page table mapper.
// ----------------------------------------------------------------------------
package tlpm_pkg;
  localparam int DIR_ENTRIES_DEF = 1024;
  localparam int POOL_TABLES_DEF = 16;
  localparam int PAGE_SLOTS = 1024;
  localparam int PE_W = 25;

  localparam logic [2:0] CMD_MAP_LOW  = 3'd0;
  localparam logic [2:0] CMD_MAP_HIGH = 3'd1;
  localparam logic [2:0] CMD_SET_OPT  = 3'd2;
  localparam logic [2:0] CMD_SET_TGT  = 3'd3;
  localparam logic [2:0] CMD_GET_OPT  = 3'd4;
  localparam logic [2:0] CMD_XLATE    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_TBL  = 2'd1;
  localparam logic [1:0] ST_NO_POOL = 2'd2;

  localparam logic [9:0] LAST_SLOT = 10'd1023;
  localparam logic [9:0] HIGH_SLOT = 10'd1022;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] physical_address;
    logic [31:0] virtual_address;
    logic        writable;
    logic        user;
    logic [1:0]  caching;
  } cmd_t;

  // option bits as stored in a page entry: {cd, wt, user, writable}
  function automatic logic [3:0] opt_bits(input logic w, input logic u,
                                          input logic [1:0] c);
    opt_bits = {c[1], c[0], u, w};
  endfunction
endpackage

>>> sv/two_level_page_table_mapper_unit.sv
`timescale 1ns / 1ps
// Flow: a command beat passes the directory check, a page read for lookups, the
// modify state, an advance for maps and the output state; an unknown command goes
// straight to output, and a map that takes a new table first clears its slots.
// One command is in execution at a time; the next is taken only once the result
// beat is accepted. Reset: synchronous; clears counters and pool usage, then a
// sweep clears the directory while incoming beats wait in the queue.
// ----------------------------------------------------------------------------
// two_level_page_table_mapper_unit
// Two-level page directory and page table pool with streaming commands.
// ----------------------------------------------------------------------------
module two_level_page_table_mapper_unit #(
  parameter int POOL_TABLES = tlpm_pkg::POOL_TABLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0], physical_address[34:3], virtual_address[66:35],
  // writable[67], user[68], caching[70:69], zero pad
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_address[31:0], page_writable[32], page_user[33],
  // page_caching[35:34], status[37:36], zero pad
  output logic [39:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlpm_pkg::*;

  logic [4:0]  tables_available;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  cmd_t        fq_data, bq_data;
  logic [37:0] b_out;

  // register 0 only; other addresses read zero and ignore writes
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {27'd0, tables_available} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      tables_available <= 5'd16;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      tables_available <= pwdata[4:0];
    end
  end

  // drop the pad bit of the command beat
  tlpm_front u_front (
    .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata[70:0]),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  // queue decouples command intake from execution
  tlpm_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
    .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
  );

  tlpm_back #(.POOL_TABLES(POOL_TABLES)) u_back (
    .clk(clk), .rst(rst), .tables_available(tables_available),
    .cmd_valid(bq_valid), .cmd_ready(bq_ready), .cmd(bq_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(b_out)
  );

  assign m_tdata = {2'b00, b_out};
endmodule

>>> sv/tlpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/tlpm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module tlpm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tlpm_pkg::cmd_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tlpm_pkg::cmd_t out_data
);
  import tlpm_pkg::*;
  `include "two_level_page_table_mapper_unit_macros.svh"

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slots[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_valid && out_ready) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

  `TLPM_ASSERT_IMP(a_q_cnt, clk, rst, 1'b1, count != 2'd3, "queue count overflow")
  `TLPM_ASSERT_IMP(a_q_ptr, clk, rst, count == 2'd0 || count == 2'd2,
                   wr_ptr == rd_ptr, "queue pointers inconsistent")
  `TLPM_ASSERT_IMP(a_q_ptr1, clk, rst, count == 2'd1, wr_ptr != rd_ptr,
                   "queue pointers inconsistent for one entry")
endmodule

>>> sv/tlpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_back
// Executes commands against the directory and the page table memory.
// Both tables live in registered-read RAMs; the directory is swept clear
// entry by entry after reset before the first command is taken.
// ----------------------------------------------------------------------------
module tlpm_back #(
  parameter int POOL_TABLES = tlpm_pkg::POOL_TABLES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [4:0]     tables_available,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  tlpm_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [37:0]    out_data
);
  import tlpm_pkg::*;
  `include "two_level_page_table_mapper_unit_macros.svh"

  localparam int TW = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int CW = $clog2(POOL_TABLES + 1);
  localparam int AW = $clog2(POOL_TABLES * PAGE_SLOTS);
  localparam int DW = TW + 3;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DCHK, S_CLEAR, S_PREAD, S_MOD, S_ADV, S_OUT
  } state_t;
  typedef struct packed {
    logic          present;
    logic          writable;
    logic          user;
    logic [TW-1:0] table_id;
  } dir_t;

  state_t        state;
  cmd_t          cur;
  dir_t          de;
  logic [9:0]    low_dir, low_page, high_dir, high_page;
  logic [CW-1:0] tables_used;
  logic [9:0]    d, p;
  logic [9:0]    clr_cnt;
  logic          is_map;
  logic          adv_clr;
  logic [9:0]    adv_dir;

  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [PE_W-1:0] ram_wdata, ram_rdata;

  logic       dir_we;
  logic [9:0] dir_addr;
  dir_t       dir_wdata, dir_rdata;

  logic [31:0] r_addr;
  logic        r_w, r_u;
  logic [1:0]  r_c, r_st;

  logic [CW-1:0] limit;
  logic [9:0]    cmd_d, cmd_p;
  logic          first;
  logic [3:0]    opts;

  assign limit = ({{(CW > 5 ? CW - 5 : 1){1'b0}}, tables_available} > POOL_TABLES)
               ? CW'(POOL_TABLES) : CW'(tables_available);
  // slot addressed by the command at the queue head
  assign cmd_d = (cmd.command == CMD_MAP_HIGH) ? high_dir
               : (cmd.command == CMD_MAP_LOW) ? low_dir : cmd.virtual_address[31:22];
  assign cmd_p = (cmd.command == CMD_MAP_HIGH) ? high_page
               : (cmd.command == CMD_MAP_LOW) ? low_page : cmd.virtual_address[21:12];
  assign first  = (cur.command == CMD_MAP_HIGH)
                ? (high_page == LAST_SLOT || (high_dir == LAST_SLOT && high_page == HIGH_SLOT))
                : (low_page == 10'd0);
  assign opts   = opt_bits(cur.writable, cur.user, cur.caching);

  assign cmd_ready = (state == S_IDLE) && !out_valid;

  // directory port: sweep, lookup, allocation, flag update, advance clear
  always_comb begin
    dir_we    = 1'b0;
    dir_addr  = d;
    dir_wdata = '0;
    unique case (state)
      S_INIT: begin
        dir_we   = 1'b1;
        dir_addr = clr_cnt;
      end
      S_IDLE: begin
        dir_addr = cmd_d;
      end
      S_DCHK: begin
        if (is_map && first && tables_used < limit) begin
          dir_we    = 1'b1;
          dir_wdata = '{present: 1'b1, writable: 1'b0, user: 1'b0,
                        table_id: TW'(tables_used)};
        end
      end
      S_MOD: begin
        if (is_map) begin
          dir_we    = 1'b1;
          dir_wdata = '{present: 1'b1, writable: de.writable | opts[0],
                        user: de.user | opts[1], table_id: de.table_id};
        end
      end
      S_ADV: begin
        dir_we   = adv_clr;
        dir_addr = adv_dir;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = AW'({de.table_id, p});
    unique case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = AW'({de.table_id, clr_cnt});
      end
      S_MOD: begin
        if (is_map) begin
          ram_we    = 1'b1;
          ram_wdata = {cur.physical_address[31:12], opts, 1'b1};
        end else if (cur.command == CMD_SET_OPT) begin
          ram_we    = 1'b1;
          ram_wdata = {ram_rdata[24:5], opts, ram_rdata[0]};
        end else if (cur.command == CMD_SET_TGT) begin
          ram_we    = 1'b1;
          ram_wdata = {cur.physical_address[31:12], ram_rdata[4:0]};
        end
      end
      default: ;
    endcase
  end

  tlpm_ram #(.WIDTH(DW), .DEPTH(DIR_ENTRIES_DEF)) u_dir (
    .clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_rdata)
  );

  tlpm_ram #(.WIDTH(PE_W), .DEPTH(POOL_TABLES * PAGE_SLOTS)) u_pages (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign out_data = {r_st, r_c, r_u, r_w, r_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      out_valid   <= 1'b0;
      low_dir     <= 10'd0;
      low_page    <= 10'd0;
      high_dir    <= LAST_SLOT;
      high_page   <= HIGH_SLOT;
      tables_used <= '0;
      clr_cnt     <= 10'd0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          clr_cnt <= clr_cnt + 10'd1;
          if (clr_cnt == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur     <= cmd;
            r_addr  <= '0;
            r_w     <= 1'b0;
            r_u     <= 1'b0;
            r_c     <= 2'd0;
            r_st    <= ST_OK;
            adv_clr <= 1'b0;
            d       <= cmd_d;
            p       <= cmd_p;
            unique case (cmd.command) inside
              CMD_MAP_LOW, CMD_MAP_HIGH: begin
                is_map <= 1'b1;
                state  <= S_DCHK;
              end
              CMD_SET_OPT, CMD_SET_TGT, CMD_GET_OPT, CMD_XLATE: begin
                is_map <= 1'b0;
                state  <= S_DCHK;
              end
              default: begin
                is_map <= 1'b0;
                state  <= S_OUT;
              end
            endcase
          end
        end
        S_DCHK: begin
          // directory entry is on the RAM output now
          if (is_map && first) begin
            if (tables_used >= limit) begin
              r_st  <= ST_NO_POOL;
              state <= S_OUT;
            end else begin
              de          <= '{present: 1'b1, writable: 1'b0, user: 1'b0,
                               table_id: TW'(tables_used)};
              clr_cnt     <= 10'd0;
              tables_used <= tables_used + CW'(1);
              state       <= S_CLEAR;
            end
          end else if (!dir_rdata.present) begin
            r_st  <= ST_NO_TBL;
            state <= S_OUT;
          end else begin
            de    <= dir_rdata;
            state <= is_map ? S_MOD : S_PREAD;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 10'd1;
          if (clr_cnt == LAST_SLOT) begin
            state <= S_MOD;
          end
        end
        S_PREAD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (is_map) begin
            state  <= S_ADV;
            r_addr <= {d, p, cur.physical_address[11:0]};
            if (cur.command == CMD_MAP_HIGH) begin
              if (high_page == 10'd0) begin
                high_page <= LAST_SLOT;
                high_dir  <= high_dir - 10'd1;
                adv_dir   <= high_dir - 10'd1;
                adv_clr   <= 1'b1;
              end else begin
                high_page <= high_page - 10'd1;
              end
            end else begin
              if (low_page == LAST_SLOT) begin
                low_page <= 10'd0;
                low_dir  <= low_dir + 10'd1;
                adv_dir  <= low_dir + 10'd1;
                adv_clr  <= 1'b1;
              end else begin
                low_page <= low_page + 10'd1;
              end
            end
          end else begin
            state <= S_OUT;
            if (cur.command == CMD_GET_OPT) begin
              r_w <= ram_rdata[1];
              r_u <= ram_rdata[2];
              r_c <= {ram_rdata[4], ram_rdata[3]};
            end else if (cur.command == CMD_XLATE) begin
              r_addr <= {ram_rdata[24:5], cur.virtual_address[11:0]};
            end
          end
        end
        S_ADV: begin
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TLPM_ASSERT_IMP(a_b_pool, clk, rst, 1'b1, tables_used <= CW'(POOL_TABLES),
                   "pool overdrawn")
  `TLPM_ASSERT_NEXT(a_b_clr, clk, rst, state == S_CLEAR && clr_cnt != LAST_SLOT,
                    state == S_CLEAR, "clear sweep cut short")
  `TLPM_ASSERT_IMP(a_b_rdy, clk, rst, cmd_ready, !out_valid && state == S_IDLE,
                   "accept while busy")
endmodule

>>> sv/tlpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpm_front
// Accepts command beats and unpacks them into the command queue.
// ----------------------------------------------------------------------------
module tlpm_front (
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [70:0]    s_tdata,
  output logic           q_valid,
  input  logic           q_ready,
  output tlpm_pkg::cmd_t q_data
);
  import tlpm_pkg::*;

  // unpack the beat; unknown commands still travel and execute as no-ops
  assign q_data.command          = s_tdata[2:0];
  assign q_data.physical_address = s_tdata[34:3];
  assign q_data.virtual_address  = s_tdata[66:35];
  assign q_data.writable         = s_tdata[67];
  assign q_data.user             = s_tdata[68];
  assign q_data.caching          = s_tdata[70:69];
  assign q_valid  = s_tvalid && !rst;
  assign s_tready = q_ready && !rst;
endmodule

>>> tb/tb_two_level_page_table_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_page_table_mapper_unit
// Self-checking bench for the two-level page table mapper. A directed table
// covers reset state, pool exhaustion, empty directories, option and target
// updates and unknown commands; random command streams then advance both map
// counters under several pool limits. Every result beat is compared against
// its typed row result or an in-bench page table predictor.
// ----------------------------------------------------------------------------
module tb_two_level_page_table_mapper_unit;
  import tlpm_pkg::*;

  localparam int NUM_TABLES = 16;
  localparam logic [2:0] CMD_BAD_A = 3'd6;
  localparam logic [2:0] CMD_BAD_B = 3'd7;

  // Page entry bit layout: present, writable, user, write-through, disable.
  localparam int PE_P  = 0;
  localparam int PE_WR = 1;
  localparam int PE_US = 2;
  localparam int PE_WT = 3;
  localparam int PE_CD = 4;

  typedef struct packed {
    logic [31:0] address;
    logic        wr;
    logic        us;
    logic [1:0]  cache;
    logic [1:0]  status;
  } map_result_t;

  typedef struct packed {
    logic       present;
    logic       wr;
    logic       us;
    logic [4:0] table_id;
  } dir_slot_t;

  typedef struct {
    cmd_t        cmd;
    bit          typed;
    map_result_t result;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  two_level_page_table_mapper_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: mirror of directory, table pool and both map counters.
  logic [4:0]  pool_limit_reg;
  logic [9:0]  low_dir, low_slot, high_dir, high_slot;
  logic [4:0]  pool_taken;
  dir_slot_t   pg_dir [1024];
  logic [24:0] pg_mem [NUM_TABLES*1024];

  map_result_t pending_results[$];
  logic [31:0] mapped_pages[$];
  int          error_count;
  int          burst_left;
  stim_row_t   directed[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [3:0] pack_opts(input logic w, input logic u,
                                           input logic [1:0] c);
    return {c[1] | (c == 2'd3 ? 1'b1 : 1'b0), c[0], u, w};
  endfunction

  function automatic int page_index(input logic [9:0] d, input logic [9:0] p);
    if (!pg_dir[d].present || pg_dir[d].table_id >= NUM_TABLES) return -1;
    return int'(pg_dir[d].table_id) * 1024 + int'(p);
  endfunction

  // Place one page at (d, p); first set when a fresh table must be taken.
  task automatic map_one(input logic [9:0] d, input logic [9:0] p, input bit first,
                         input cmd_t c, output map_result_t r);
    logic [4:0] lim;
    logic [3:0] opts;
    int         idx;
    lim = (pool_limit_reg < NUM_TABLES) ? pool_limit_reg : 5'(NUM_TABLES);
    r = '0;
    if (first) begin
      if (pool_taken >= lim) begin
        r.status = ST_NO_POOL;
        return;
      end
      pg_dir[d] = '{present: 1'b1, wr: 1'b0, us: 1'b0, table_id: pool_taken};
      for (int i = 0; i < 1024; i++) pg_mem[int'(pool_taken)*1024 + i] = '0;
      pool_taken++;
    end else if (!pg_dir[d].present) begin
      r.status = ST_NO_TBL;
      return;
    end
    idx = page_index(d, p);
    if (idx < 0) begin
      r.status = ST_NO_TBL;
      return;
    end
    opts = pack_opts(c.writable, c.user, c.caching);
    pg_mem[idx] = {c.physical_address[31:12], opts, 1'b1};
    if (opts[0]) pg_dir[d].wr = 1'b1;
    if (opts[1]) pg_dir[d].us = 1'b1;
    r.address = {d, p, c.physical_address[11:0]};
    r.status  = ST_OK;
  endtask

  // Advance the predictor by one command and produce its result.
  task automatic predict_mapping(input cmd_t c, output map_result_t r);
    logic [9:0]  vd, vp;
    logic [24:0] pe;
    int          idx;
    bit          first;
    vd = c.virtual_address[31:22];
    vp = c.virtual_address[21:12];
    r  = '0;
    case (c.command)
      CMD_MAP_LOW: begin
        map_one(low_dir, low_slot, low_slot == 10'd0, c, r);
        if (r.status == ST_OK) begin
          if (low_slot == LAST_SLOT) begin
            low_slot = '0;
            low_dir  = low_dir + 10'd1;
            pg_dir[low_dir] = '0;
          end else begin
            low_slot++;
          end
        end
      end
      CMD_MAP_HIGH: begin
        first = (high_slot == LAST_SLOT) || (high_dir == LAST_SLOT && high_slot == HIGH_SLOT);
        map_one(high_dir, high_slot, first, c, r);
        if (r.status == ST_OK) begin
          if (high_slot == 10'd0) begin
            high_slot = LAST_SLOT;
            high_dir  = high_dir - 10'd1;
            pg_dir[high_dir] = '0;
          end else begin
            high_slot--;
          end
        end
      end
      CMD_SET_OPT, CMD_SET_TGT, CMD_GET_OPT, CMD_XLATE: begin
        idx = page_index(vd, vp);
        if (idx < 0) begin
          r.status = ST_NO_TBL;
        end else begin
          pe = pg_mem[idx];
          case (c.command)
            CMD_SET_OPT: pg_mem[idx] = {pe[24:5], pack_opts(c.writable, c.user, c.caching),
                                        pe[PE_P]};
            CMD_SET_TGT: pg_mem[idx] = {c.physical_address[31:12], pe[4:0]};
            CMD_GET_OPT: begin
              r.wr    = pe[PE_WR];
              r.us    = pe[PE_US];
              r.cache = {pe[PE_CD], pe[PE_WT]};
            end
            default: r.address = {pe[24:5], c.virtual_address[11:0]};
          endcase
        end
      end
      default: r = '0;
    endcase
  endtask

  function automatic stim_row_t row(input logic [2:0] op, input logic [31:0] pa,
                                    input logic [31:0] va, input logic w, input logic u,
                                    input logic [1:0] c, input bit typed,
                                    input map_result_t r);
    stim_row_t s;
    s.cmd    = '{command: op, physical_address: pa, virtual_address: va,
                 writable: w, user: u, caching: c};
    s.typed  = typed;
    s.result = r;
    return s;
  endfunction

  // Drive one command beat and hold it until accepted.
  task automatic send_command(input cmd_t c, input bit typed, input map_result_t typed_res);
    map_result_t r;
    int          gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, c.caching, c.user, c.writable, c.virtual_address,
                 c.physical_address, c.command};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_mapping(c, r);
    pending_results.push_back(typed ? typed_res : r);
    if (r.status == ST_OK && c.command inside {CMD_MAP_LOW, CMD_MAP_HIGH})
      mapped_pages.push_back({r.address[31:12], 12'h000});
    // Burst bookkeeping: drop valid for a random gap when the burst ends.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic write_pool_limit(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 1'b0;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_limit_reg = value[4:0];
  endtask

  // Hold off until every result is back, plus a margin for in-flight work.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      c.command = CMD_MAP_HIGH;
    else if (pick < 66) c.command = CMD_MAP_LOW;
    else if (pick < 68) c.command = ($urandom_range(0, 1) != 0) ? CMD_BAD_B : CMD_BAD_A;
    else                c.command = 3'($urandom_range(CMD_SET_OPT, CMD_XLATE));
    c.physical_address = $urandom;
    // Aim most lookups at pages that are actually mapped.
    if (mapped_pages.size() != 0 && $urandom_range(0, 3) != 0)
      c.virtual_address = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)] |
                          32'($urandom_range(0, 12'hfff));
    else
      c.virtual_address = $urandom;
    c.writable = 1'($urandom);
    c.user     = 1'($urandom);
    c.caching  = 2'($urandom);
    return c;
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_command(random_command(), 1'b0, '0);
    drain_results();
  endtask

  // Receiver stalls in modes: always ready, random stalls, long hold-offs.
  int ready_mode, ready_left;
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_mode <= 0;
      ready_left <= 0;
    end else begin
      if (ready_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        ready_left <= $urandom_range(5, 60);
      end else begin
        ready_left <= ready_left - 1;
      end
      case (ready_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compare each result beat with the oldest pending prediction.
  always @(posedge clk) begin : check_results
    map_result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{address: m_tdata[31:0], wr: m_tdata[32], us: m_tdata[33],
              cache: m_tdata[35:34], status: m_tdata[37:36]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.address !== want.address) begin
          $display("%0t: result_address expected %h actual %h", $time, want.address,
                   got.address);
          error_count++;
        end
        if (got.wr !== want.wr) begin
          $display("%0t: page_writable expected %b actual %b", $time, want.wr, got.wr);
          error_count++;
        end
        if (got.us !== want.us) begin
          $display("%0t: page_user expected %b actual %b", $time, want.us, got.us);
          error_count++;
        end
        if (got.cache !== want.cache) begin
          $display("%0t: page_caching expected %0d actual %0d", $time, want.cache,
                   got.cache);
          error_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 1'b0;
    pwdata         = '0;
    error_count    = 0;
    burst_left     = 4;
    pool_limit_reg = 5'd16;
    low_dir        = '0;
    low_slot       = '0;
    high_dir       = LAST_SLOT;
    high_slot      = HIGH_SLOT;
    pool_taken     = '0;
    for (int i = 0; i < 1024; i++) pg_dir[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; typed rows carry results readable at a glance.
    directed.push_back(row(CMD_GET_OPT, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, ST_NO_TBL}));
    directed.push_back(row(CMD_XLATE, 0, 32'hffffffff, 1, 1, 3, 1,
                           '{0, 0, 0, 0, ST_NO_TBL}));
    directed.push_back(row(CMD_MAP_LOW, 32'hffffffff, 0, 1, 1, 3, 1,
                           '{32'h00000fff, 0, 0, 0, ST_OK}));
    // Pool limit of one is used up, so the top directory cannot get a table.
    directed.push_back(row(CMD_MAP_HIGH, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, ST_NO_POOL}));
    directed.push_back(row(CMD_GET_OPT, 0, 0, 0, 0, 0, 1, '{0, 1, 1, 3, ST_OK}));
    directed.push_back(row(CMD_XLATE, 0, 32'h00000abc, 0, 0, 0, 1,
                           '{32'hfffffabc, 0, 0, 0, ST_OK}));
    directed.push_back(row(CMD_SET_OPT, 0, 0, 0, 0, 0, 0, '0));
    directed.push_back(row(CMD_GET_OPT, 0, 0, 0, 0, 0, 0, '0));
    directed.push_back(row(CMD_SET_TGT, 0, 32'h00000123, 0, 0, 0, 0, '0));
    directed.push_back(row(CMD_XLATE, 0, 32'h00000fff, 0, 0, 0, 0, '0));
    // Slot 1 of the first table is cleared but not present yet.
    directed.push_back(row(CMD_GET_OPT, 0, 32'h00001000, 0, 0, 0, 0, '0));
    directed.push_back(row(CMD_SET_OPT, 0, 32'h00001000, 1, 0, 2, 0, '0));
    directed.push_back(row(CMD_GET_OPT, 0, 32'h00001000, 0, 0, 0, 0, '0));
    directed.push_back(row(CMD_SET_TGT, 32'habcde000, 32'h00001000, 0, 0, 0, 0, '0));
    directed.push_back(row(CMD_XLATE, 0, 32'h00001fff, 0, 0, 0, 0, '0));
    directed.push_back(row(CMD_MAP_LOW, 32'h12345678, 0, 0, 1, 1, 0, '0));
    directed.push_back(row(CMD_MAP_LOW, 0, 0, 0, 0, 0, 0, '0));
    directed.push_back(row(CMD_BAD_A, 32'hffffffff, 32'hffffffff, 1, 1, 3, 1, '0));
    directed.push_back(row(CMD_BAD_B, 32'hffffffff, 0, 1, 1, 3, 1, '0));
    directed.push_back(row(CMD_SET_TGT, 32'h1000, 32'h00400000, 1, 1, 1, 1,
                           '{0, 0, 0, 0, ST_NO_TBL}));
    directed.push_back(row(CMD_GET_OPT, 0, 32'h00002000, 0, 0, 0, 0, '0));

    write_pool_limit(32'd1);
    foreach (directed[i]) send_command(directed[i].cmd, directed[i].typed,
                                       directed[i].result);
    drain_results();

    // Random phases under the largest pool limit, a middle one and a limit of one.
    write_pool_limit(32'd16);
    run_random(450);
    write_pool_limit(32'd8);
    run_random(450);
    write_pool_limit(32'd1);
    run_random(80);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
